// File: hw/rtl/fraction_reducer_core_assert.svh
// assertion macros for the fraction reducer core
`ifndef FRACTION_REDUCER_CORE_ASSERT_SVH
`define FRACTION_REDUCER_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define FR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising clock edge out of reset
`define FR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fr_pkg.sv
// shared types and constants of the fraction reducer
package fr_pkg;

  // operand width and derived widths
  localparam int DATA_WIDTH = 32;
  localparam int MAG_W      = DATA_WIDTH - 1;
  localparam int SHIFT_W    = $clog2(MAG_W);
  localparam int CNT_W      = $clog2(MAG_W);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_HOLD
  } fr_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } fr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } fr_status_t;

endpackage

// File: hw/rtl/fr_in_if.sv
// input channel: signed numerator and denominator item
interface fr_in_if;
  import fr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// File: hw/rtl/fr_out_if.sv
// result channel: reduced fraction item with flags
interface fr_out_if;
  import fr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] reduced_numerator;
  logic        [MAG_W-1:0]      reduced_denominator;
  logic                         is_whole;
  logic                         bad_denominator;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output is_whole, output bad_denominator, input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  input is_whole, input bad_denominator, output ready);
endinterface

// File: hw/rtl/fr_ctrl.sv
// controller state machine of the fraction reducer
module fr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fr_pkg::fr_status_t status,
  output fr_pkg::fr_cmd_t    cmd
);
  import fr_pkg::*;

  fr_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  // state and output slot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.special) begin
          state_nxt = ST_HOLD;
        end else if (status.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output slot: filled on load, emptied when the item is taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/fr_dpath.sv
// datapath of the fraction reducer: binary gcd, two shared-count dividers, result register
module fr_dpath (
  input  logic                                 clk,
  input  fr_pkg::fr_cmd_t                      cmd,
  output fr_pkg::fr_status_t                   status,
  input  logic signed [fr_pkg::DATA_WIDTH-1:0] numerator,
  input  logic signed [fr_pkg::DATA_WIDTH-1:0] denominator,
  output logic signed [fr_pkg::DATA_WIDTH-1:0] reduced_numerator,
  output logic        [fr_pkg::MAG_W-1:0]      reduced_denominator,
  output logic                                 is_whole,
  output logic                                 bad_denominator
);
  import fr_pkg::*;

  // saturated magnitude of a two's complement value
  function automatic logic [MAG_W-1:0] sat_mag(input logic [DATA_WIDTH-1:0] raw);
    logic [DATA_WIDTH-1:0] negv;
    logic [MAG_W-1:0]      res;
    negv = -raw;
    if (!raw[DATA_WIDTH-1]) begin
      res = raw[MAG_W-1:0];
    end else if (raw[MAG_W-1:0] == '0) begin
      res = '1;
    end else begin
      res = negv[MAG_W-1:0];
    end
    return res;
  endfunction

  logic [MAG_W-1:0]   nmag_r, dmag_r;
  logic [MAG_W-1:0]   a_r, b_r;
  logic [SHIFT_W-1:0] k_r;
  logic               sign_r, zero_num_r, zero_den_r;
  logic [MAG_W-1:0]   g_r, rem_n_r, rem_d_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [DATA_WIDTH-1:0] res_num_r;
  logic [MAG_W-1:0]   res_den_r;
  logic               res_whole_r, res_bad_r;

  logic [MAG_W-1:0]   in_nmag, in_dmag;
  logic [MAG_W:0]     ab_diff;
  logic [MAG_W:0]     trial_n, trial_d, diff_n, diff_d;
  logic [DATA_WIDTH-1:0] num_ext;

  assign in_nmag = sat_mag(numerator);
  assign in_dmag = sat_mag(denominator);
  assign ab_diff = {1'b0, a_r} - {1'b0, b_r};

  // restoring division trial subtracts, both against the same divisor
  assign trial_n = {rem_n_r, nmag_r[MAG_W-1]};
  assign trial_d = {rem_d_r, dmag_r[MAG_W-1]};
  assign diff_n  = trial_n - {1'b0, g_r};
  assign diff_d  = trial_d - {1'b0, g_r};

  assign num_ext = {1'b0, nmag_r};

  // status back to the controller
  assign status.special  = zero_num_r | zero_den_r;
  assign status.gcd_done = (a_r == '0) || (b_r == '0);
  assign status.div_last = (cnt_r == '0);

  // operand capture and binary gcd steps
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      nmag_r     <= in_nmag;
      dmag_r     <= in_dmag;
      a_r        <= in_nmag;
      b_r        <= in_dmag;
      k_r        <= '0;
      sign_r     <= numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
      zero_num_r <= (in_nmag == '0);
      zero_den_r <= (in_dmag == '0);
    end else if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + SHIFT_W'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (!ab_diff[MAG_W]) begin
        a_r <= ab_diff[MAG_W:1];
      end else begin
        b_r <= MAG_W'(({1'b0, b_r} - {1'b0, a_r}) >> 1);
      end
    end else if (cmd.div_step) begin
      // dividends shift out as quotient bits shift in
      nmag_r <= {nmag_r[MAG_W-2:0], ~diff_n[MAG_W]};
      dmag_r <= {dmag_r[MAG_W-2:0], ~diff_d[MAG_W]};
    end
  end

  // divider setup and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g_r     <= MAG_W'((a_r | b_r) << k_r);
      rem_n_r <= '0;
      rem_d_r <= '0;
      cnt_r   <= CNT_W'(MAG_W - 1);
    end else if (cmd.div_step) begin
      rem_n_r <= diff_n[MAG_W] ? trial_n[MAG_W-1:0] : diff_n[MAG_W-1:0];
      rem_d_r <= diff_d[MAG_W] ? trial_d[MAG_W-1:0] : diff_d[MAG_W-1:0];
      cnt_r   <= cnt_r - CNT_W'(1);
    end
  end

  // result register, with zero denominator and zero numerator cases
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (zero_den_r) begin
        res_num_r   <= '0;
        res_den_r   <= '0;
        res_whole_r <= 1'b0;
        res_bad_r   <= 1'b1;
      end else if (zero_num_r) begin
        res_num_r   <= '0;
        res_den_r   <= MAG_W'(1);
        res_whole_r <= 1'b1;
        res_bad_r   <= 1'b0;
      end else begin
        res_num_r   <= sign_r ? -num_ext : num_ext;
        res_den_r   <= dmag_r;
        res_whole_r <= (dmag_r == MAG_W'(1));
        res_bad_r   <= 1'b0;
      end
    end
  end

  assign reduced_numerator   = res_num_r;
  assign reduced_denominator = res_den_r;
  assign is_whole            = res_whole_r;
  assign bad_denominator     = res_bad_r;

endmodule

// File: hw/rtl/fraction_reducer_core.sv
// fraction reducer top level: controller, datapath and assertions
//
// Usage: offer a signed numerator/denominator item on in_ch (valid/ready); the
// fraction in lowest terms comes back as one item on out_ch, sign on the
// numerator, denominator positive. A zero numerator gives 0/1 with is_whole; a
// zero denominator sets bad_denominator with all other fields zero. The most
// negative input value is treated as its positive neighbor negated.
// Timing: one item is in work at a time. After acceptance, the binary gcd runs
// one step per cycle (each step shortens an operand by at least one bit), then
// the divider is set up, then both divisions by the gcd run together in the
// restoring divider, one quotient bit per cycle, then the result register is
// loaded; the zero cases skip the divider. The next item can be accepted in
// the cycle after the load.
// in_ch.ready is high only when no item is in work; the next item can be taken
// while the previous result still sits in the output register.
// Stall: if out_ch.ready stays low, a finished item waits inside until the
// output register frees; out_ch holds its item steady until taken.
// Reset: synchronous active-low rst_n empties the block; nothing is in work
// and out_ch.valid is low afterward.
module fraction_reducer_core (
  input logic      clk,
  input logic      rst_n,
  fr_in_if.sink    in_ch,
  fr_out_if.source out_ch
);
  import fr_pkg::*;

  fr_cmd_t    cmd;
  fr_status_t status;

  // sequencing
  fr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic
  fr_dpath u_dpath (
    .clk                 (clk),
    .cmd                 (cmd),
    .status              (status),
    .numerator           (in_ch.numerator),
    .denominator         (in_ch.denominator),
    .reduced_numerator   (out_ch.reduced_numerator),
    .reduced_denominator (out_ch.reduced_denominator),
    .is_whole            (out_ch.is_whole),
    .bad_denominator     (out_ch.bad_denominator)
  );

  // checks
  `include "fraction_reducer_core_assert.svh"

  `FR_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")
  `FR_ASSERT_NEXT(a_load_fills_slot, cmd.load_out, out_ch.valid, "loaded item not offered")
  `FR_ASSERT_NOW(a_bad_fields_zero, out_ch.valid && out_ch.bad_denominator, (out_ch.reduced_denominator == '0) && !out_ch.is_whole && (out_ch.reduced_numerator == '0), "error item with nonzero fields")
  `FR_ASSERT_NOW(a_good_den_nonzero, out_ch.valid && !out_ch.bad_denominator, out_ch.reduced_denominator != '0, "zero denominator in good item")

endmodule
